FILE: hw/rtl/rbdq_pkg.sv
// Shared types and constants for the ring-buffer deque queue.
// Op and status codes, index and count widths, store request bundle.
// No dependencies.
package rbdq_pkg;

	localparam int DEPTH         = 512;
	localparam int ELEMENT_WIDTH = 64;
	localparam int VAL_W         = 64;
	localparam int OCC_W         = 10;
	localparam int IDX_W         = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W         = $clog2(DEPTH + 1);

	typedef enum logic [2:0] {
		OP_ENQ_BACK  = 3'd0,
		OP_ENQ_FRONT = 3'd1,
		OP_PEEK      = 3'd2,
		OP_POP       = 3'd3,
		OP_DEQ       = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef struct packed {
		logic                     we;
		logic [IDX_W-1:0]         waddr;
		logic [ELEMENT_WIDTH-1:0] wdata;
		logic                     re;
		logic [IDX_W-1:0]         raddr;
	} store_req_t;

endpackage

FILE: hw/rtl/rbdq_store.sv
// Entry store of the deque: one write port, one read port, registered read.
// Depends on rbdq_pkg.
module rbdq_store (
	input  logic                              clk,
	input  rbdq_pkg::store_req_t              req,
	output logic [rbdq_pkg::ELEMENT_WIDTH-1:0] rd_data
);
	import rbdq_pkg::*;

	logic [ELEMENT_WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (req.re) begin
			rd_data <= mem[req.raddr];
		end
	end

endmodule

FILE: hw/rtl/rbdq_ctrl.sv
// Head/tail/count control of the deque and the registered response stage.
// Drives store requests; depends on rbdq_pkg.
module rbdq_ctrl (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic [2:0]                         op,
	input  logic [rbdq_pkg::VAL_W-1:0]         item_value,
	output rbdq_pkg::store_req_t               req,
	input  logic [rbdq_pkg::ELEMENT_WIDTH-1:0] rd_data,
	output logic                               done,
	output logic [rbdq_pkg::VAL_W-1:0]         read_value,
	output logic [1:0]                         status,
	output logic [rbdq_pkg::OCC_W-1:0]         occupancy,
	output logic                               is_empty
);
	import rbdq_pkg::*;

	logic [IDX_W-1:0] head_q, tail_q, head_d, tail_d;
	logic [CNT_W-1:0] count_q, count_d;
	logic             full, empty;
	logic             rd_hit;
	status_t          st_d;
	op_t              op_c;

	logic             valid_s1;
	logic             rd_hit_s1;
	status_t          st_s1;
	logic [CNT_W-1:0] count_s1;

	function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] i);
		return (i == IDX_W'(DEPTH - 1)) ? '0 : i + IDX_W'(1);
	endfunction

	function automatic logic [IDX_W-1:0] wrap_dec(input logic [IDX_W-1:0] i);
		return (i == '0) ? IDX_W'(DEPTH - 1) : i - IDX_W'(1);
	endfunction

	assign op_c  = op_t'(op);
	assign full  = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);

	always_comb begin
		head_d    = head_q;
		tail_d    = tail_q;
		count_d   = count_q;
		st_d      = ST_DONE;
		rd_hit    = 1'b0;
		req.we    = 1'b0;
		req.waddr = tail_q;
		req.wdata = item_value[ELEMENT_WIDTH-1:0];
		req.re    = 1'b0;
		req.raddr = head_q;
		if (start) begin
			case (op_c)
				OP_ENQ_BACK: begin
					if (full) begin
						st_d = ST_FULL;
					end else begin
						req.we  = 1'b1;
						tail_d  = wrap_inc(tail_q);
						count_d = count_q + CNT_W'(1);
					end
				end
				OP_ENQ_FRONT: begin
					if (full) begin
						st_d = ST_FULL;
					end else begin
						req.we    = 1'b1;
						req.waddr = wrap_dec(head_q);
						head_d    = wrap_dec(head_q);
						count_d   = count_q + CNT_W'(1);
					end
				end
				OP_PEEK: begin
					if (empty) begin
						st_d = ST_EMPTY;
					end else begin
						req.re = 1'b1;
						rd_hit = 1'b1;
					end
				end
				OP_POP: begin
					if (empty) begin
						st_d = ST_EMPTY;
					end else begin
						head_d  = wrap_inc(head_q);
						count_d = count_q - CNT_W'(1);
					end
				end
				OP_DEQ: begin
					if (empty) begin
						st_d = ST_EMPTY;
					end else begin
						req.re  = 1'b1;
						rd_hit  = 1'b1;
						head_d  = wrap_inc(head_q);
						count_d = count_q - CNT_W'(1);
					end
				end
				default: begin
					// undefined op codes leave the state alone
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q    <= '0;
			tail_q    <= '0;
			count_q   <= '0;
			valid_s1  <= 1'b0;
			rd_hit_s1 <= 1'b0;
			st_s1     <= ST_DONE;
			count_s1  <= '0;
		end else begin
			head_q    <= head_d;
			tail_q    <= tail_d;
			count_q   <= count_d;
			valid_s1  <= start;
			rd_hit_s1 <= rd_hit;
			st_s1     <= st_d;
			count_s1  <= count_d;
		end
	end

	// store read data lands in the same cycle as the response beat
	assign done       = valid_s1;
	assign read_value = rd_hit_s1 ? VAL_W'(rd_data) : '0;
	assign status     = st_s1;
	assign occupancy  = OCC_W'(count_s1);
	assign is_empty   = (count_s1 == '0);

endmodule

FILE: hw/rtl/ring_buffer_deque_queue_unit.sv
// Top level of the ring-buffer deque queue: control plus entry store.
// Depends on rbdq_pkg, rbdq_ctrl, rbdq_store.
//
//  channel  | handshake          | payload
//  ---------+--------------------+-----------------------------------------
//  command  | start / busy       | op, item_value
//  response | done (1-cycle)     | read_value, status, occupancy, is_empty
//
// One operation per cycle; busy stays low. The response beat for a command
// taken at edge N is shown in the cycle after N, set by the store's
// registered read. Head, tail and count update at edge N, so a
// command right behind sees the new state. Reset clears head, tail, count
// and the response strobe; the store holds no reset. done cannot be stalled.
module ring_buffer_deque_queue_unit (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic [2:0]                 op,
	input  logic [rbdq_pkg::VAL_W-1:0] item_value,
	output logic                       done,
	output logic [rbdq_pkg::VAL_W-1:0] read_value,
	output logic [1:0]                 status,
	output logic [rbdq_pkg::OCC_W-1:0] occupancy,
	output logic                       is_empty
);
	import rbdq_pkg::*;

	store_req_t               req;
	logic [ELEMENT_WIDTH-1:0] rd_data;

	assign busy = 1'b0;

	rbdq_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.op         (op),
		.item_value (item_value),
		.req        (req),
		.rd_data    (rd_data),
		.done       (done),
		.read_value (read_value),
		.status     (status),
		.occupancy  (occupancy),
		.is_empty   (is_empty)
	);

	rbdq_store u_store (
		.clk     (clk),
		.req     (req),
		.rd_data (rd_data)
	);

endmodule

FILE: dv/testbench.sv
// Testbench for ring_buffer_deque_queue_unit: directed corner cases, then random op mixes.
// A scoreboard class predicts each response beat in order and compares it field by field.
// Depends on rbdq_pkg and the RTL of ring_buffer_deque_queue_unit.
module testbench;
	import rbdq_pkg::*;

	localparam int IDLE_LIMIT = 400;

	typedef struct {
		logic [VAL_W-1:0] rd;
		status_t          st;
		logic [OCC_W-1:0] occ;
		logic             empty;
	} resp_t;

	class deque_scoreboard;
		logic [ELEMENT_WIDTH-1:0] slots [DEPTH];
		logic [IDX_W-1:0]         head;
		logic [IDX_W-1:0]         tail;
		logic [CNT_W-1:0]         count;
		resp_t                    resp_q[$];
		int                       errors;

		function new();
			head   = '0;
			tail   = '0;
			count  = '0;
			errors = 0;
		endfunction

		function logic [IDX_W-1:0] step_up(logic [IDX_W-1:0] i);
			return (i == IDX_W'(DEPTH - 1)) ? '0 : i + IDX_W'(1);
		endfunction

		function logic [IDX_W-1:0] step_down(logic [IDX_W-1:0] i);
			return (i == '0) ? IDX_W'(DEPTH - 1) : i - IDX_W'(1);
		endfunction

		// Update the deque copy for one accepted command and queue its response.
		function void note_command(logic [2:0] o, logic [VAL_W-1:0] v);
			resp_t r;
			r.rd = '0;
			r.st = ST_DONE;
			case (o)
				OP_ENQ_BACK: begin
					if (count >= CNT_W'(DEPTH)) begin
						r.st = ST_FULL;
					end else begin
						slots[tail] = v[ELEMENT_WIDTH-1:0];
						tail = step_up(tail);
						count = count + CNT_W'(1);
					end
				end
				OP_ENQ_FRONT: begin
					if (count >= CNT_W'(DEPTH)) begin
						r.st = ST_FULL;
					end else begin
						head = step_down(head);
						slots[head] = v[ELEMENT_WIDTH-1:0];
						count = count + CNT_W'(1);
					end
				end
				OP_PEEK: begin
					if (count == '0) r.st = ST_EMPTY;
					else r.rd = VAL_W'(slots[head]);
				end
				OP_POP: begin
					if (count == '0) begin
						r.st = ST_EMPTY;
					end else begin
						head = step_up(head);
						count = count - CNT_W'(1);
					end
				end
				OP_DEQ: begin
					if (count == '0) begin
						r.st = ST_EMPTY;
					end else begin
						r.rd = VAL_W'(slots[head]);
						head = step_up(head);
						count = count - CNT_W'(1);
					end
				end
				default: ; // unused codes leave everything as is
			endcase
			r.occ   = OCC_W'(count);
			r.empty = (count == '0);
			resp_q.push_back(r);
		endfunction

		function void check_response(logic [VAL_W-1:0] rd, logic [1:0] st,
			logic [OCC_W-1:0] occ, logic emp);
			resp_t e;
			if (resp_q.size() == 0) begin
				$display("%0t: response beat with nothing outstanding", $time);
				errors++;
				return;
			end
			e = resp_q.pop_front();
			if (rd !== e.rd) begin
				$display("%0t: read_value expected %h got %h", $time, e.rd, rd);
				errors++;
			end
			if (st !== e.st) begin
				$display("%0t: status expected %0d got %0d", $time, e.st, st);
				errors++;
			end
			if (occ !== e.occ) begin
				$display("%0t: occupancy expected %0d got %0d", $time, e.occ, occ);
				errors++;
			end
			if (emp !== e.empty) begin
				$display("%0t: is_empty expected %b got %b", $time, e.empty, emp);
				errors++;
			end
		endfunction

		function int outstanding();
			return resp_q.size();
		endfunction

		function int level();
			return int'(count);
		endfunction
	endclass

	logic             clk;
	logic             arst_n;
	logic             start;
	logic             busy;
	logic [2:0]       op;
	logic [VAL_W-1:0] item_value;
	logic             done;
	logic [VAL_W-1:0] read_value;
	logic [1:0]       status;
	logic [OCC_W-1:0] occupancy;
	logic             is_empty;

	deque_scoreboard sb = new();
	int              idle_cycles = 0;
	bit              idle_on = 1'b1;

	ring_buffer_deque_queue_unit dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.op         (op),
		.item_value (item_value),
		.done       (done),
		.read_value (read_value),
		.status     (status),
		.occupancy  (occupancy),
		.is_empty   (is_empty)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Monitor: responses first, then the command beat taken at this edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (done) sb.check_response(read_value, status, occupancy, is_empty);
			if (start && !busy) sb.note_command(op, item_value);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done) idle_cycles = 0;
			else idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t: watchdog, no beat for %0d cycles", $time, IDLE_LIMIT);
				$display("Some tests failed");
				$finish;
			end
		end
	end

	// Called and returns at a falling edge; holds start until the beat is taken.
	task automatic issue_cmd(input logic [2:0] o, input logic [VAL_W-1:0] v);
		int gap;
		if ($urandom_range(0, 19) == 0) idle_on = !idle_on;
		gap = idle_on ? $urandom_range(0, 17) : 0;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start      <= 1'b1;
		op         <= o;
		item_value <= v;
		do @(posedge clk); while (busy);
		@(negedge clk);
	endtask

	function automatic logic [VAL_W-1:0] rand_value();
		case ($urandom_range(0, 7))
			0:       return '0;
			1:       return '1;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	// enq_pct: share of enqueues; a small slice goes to the unused codes.
	function automatic logic [2:0] rand_op(int enq_pct);
		int r;
		r = $urandom_range(0, 99);
		if (r < enq_pct) return $urandom_range(0, 1) ? OP_ENQ_BACK : OP_ENQ_FRONT;
		if (r < 97) begin
			case ($urandom_range(0, 2))
				0:       return OP_PEEK;
				1:       return OP_POP;
				default: return OP_DEQ;
			endcase
		end
		return 3'($urandom_range(5, 7));
	endfunction

	task automatic run_mix(input int n, input int enq_pct);
		repeat (n) issue_cmd(rand_op(enq_pct), rand_value());
	endtask

	task automatic wait_drained();
		while (sb.outstanding() != 0) @(negedge clk);
	endtask

	initial begin
		arst_n     = 1'b0;
		start      = 1'b0;
		op         = '0;
		item_value = '0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// empty-queue reads, both enqueue ends, unused codes, wrap of head below zero
		issue_cmd(OP_PEEK, '1);
		issue_cmd(OP_POP, '1);
		issue_cmd(OP_DEQ, '0);
		issue_cmd(OP_ENQ_BACK, '1);
		issue_cmd(OP_ENQ_FRONT, '0);
		issue_cmd(OP_PEEK, '1);
		issue_cmd(OP_DEQ, '1);
		issue_cmd(OP_PEEK, '0);
		issue_cmd(3'd5, '1);
		issue_cmd(3'd6, '0);
		issue_cmd(3'd7, '1);
		issue_cmd(OP_POP, '0);
		issue_cmd(OP_PEEK, '0);
		issue_cmd(OP_ENQ_FRONT, 64'hA5A5_5A5A_F0F0_0F0F);
		issue_cmd(OP_ENQ_BACK, 64'h0123_4567_89AB_CDEF);
		issue_cmd(OP_ENQ_FRONT, 64'h8000_0000_0000_0001);
		issue_cmd(OP_DEQ, '0);
		issue_cmd(OP_DEQ, '0);
		issue_cmd(OP_DEQ, '0);
		issue_cmd(OP_DEQ, '0);

		// balanced mix hovering near empty
		run_mix(30, 48);
		start <= 1'b0;
		@(negedge clk);
		wait_drained();

		// fill to the top, then press on the full queue
		while (sb.level() < DEPTH) issue_cmd(rand_op(94), rand_value());
		run_mix(25, 85);

		// drain-heavy tail
		run_mix(40, 20);

		start <= 1'b0;
		wait_drained();
		repeat (4) @(posedge clk);
		if (sb.outstanding() != 0) begin
			$display("%0t: %0d responses never arrived", $time, sb.outstanding());
			sb.errors++;
		end
		if (sb.errors == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

FILE: filelist.f
hw/rtl/rbdq_pkg.sv
hw/rtl/rbdq_store.sv
hw/rtl/rbdq_ctrl.sv
hw/rtl/ring_buffer_deque_queue_unit.sv
dv/testbench.sv
